// ===== design/udp_ff_pkg.sv =====
// Shared constants, codes and types of the UDP frame filter.
package udp_ff_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65536;

    // Width used when frame length and header ends are compared.
    localparam int CMP_W = 18;

    localparam logic [15:0] TPID_VLAN  = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [3:0]  IPV4_VER   = 4'd4;

    localparam logic [4:0] ETH_END  = 5'd14;
    localparam logic [4:0] VLAN_END = 5'd18;
    localparam logic [5:0] IPV4_MIN = 6'd20;
    localparam logic [5:0] UDP_HDR  = 6'd8;

    localparam logic [2:0] RSN_OK        = 3'd0;
    localparam logic [2:0] RSN_SHORT     = 3'd1;
    localparam logic [2:0] RSN_NOT_IPV4  = 3'd2;
    localparam logic [2:0] RSN_BAD_HDR   = 3'd3;
    localparam logic [2:0] RSN_NOT_UDP   = 3'd4;
    localparam logic [2:0] RSN_BAD_LEN   = 3'd5;
    localparam logic [2:0] RSN_PORT      = 3'd6;
    localparam logic [2:0] RSN_PEER      = 3'd7;

    localparam logic [1:0] CFG_MATCH_PORT  = 2'd0;
    localparam logic [1:0] CFG_PEER_ENABLE = 2'd1;
    localparam logic [1:0] CFG_PEER_ADDR   = 2'd2;
    localparam logic [1:0] CFG_HASH_PAYLD  = 2'd3;

    typedef struct packed {
        logic [15:0] match_port;
        logic        peer_filter_enable;
        logic [31:0] peer_address;
        logic        hash_payload_only;
    } t_cfg;

    typedef struct packed {
        logic [15:0] outer_type;
        logic [15:0] inner_type;
        logic [7:0]  version_ihl;
        logic [7:0]  protocol;
        logic [15:0] total_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
    } t_frame;

endpackage

// ===== design/udp_frame_filter.sv =====
// Top level of the UDP frame filter: configuration registers and the two stages.
// Throughput: one frame byte per cycle while o_in_stall is low, with no gap between frames.
// The last byte passes the input register, the frame capture register and the result
// register before its verdict is valid.
// Input stall rises only when a verdict waits on a stalled output with another behind it.
// Reset is synchronous, active low; it clears configuration, frame state and valids at once.
module udp_frame_filter
    import udp_ff_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_accepted,
    output logic [2:0]  o_reject_reason,
    output logic        o_toward_server,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [15:0] o_ip_length,
    output logic [6:0]  o_window_offset,
    output logic [15:0] o_window_length
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    t_cfg             r_cfg;
    logic             snap_valid;
    logic             snap_ready;
    t_frame           snap;
    logic [POS_W-1:0] snap_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATCH_PORT:  r_cfg.match_port         <= i_cfg_data[15:0];
                CFG_PEER_ENABLE: r_cfg.peer_filter_enable <= i_cfg_data[0];
                CFG_PEER_ADDR:   r_cfg.peer_address       <= i_cfg_data;
                CFG_HASH_PAYLD:  r_cfg.hash_payload_only  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    udp_ff_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .POS_W           (POS_W)
    ) u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap),
        .o_snap_pos   (snap_pos)
    );

    udp_ff_judge #(
        .POS_W (POS_W)
    ) u_judge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_snap_valid     (snap_valid),
        .o_snap_ready     (snap_ready),
        .i_snap           (snap),
        .i_snap_pos       (snap_pos),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_accepted (o_frame_accepted),
        .o_reject_reason  (o_reject_reason),
        .o_toward_server  (o_toward_server),
        .o_source_address (o_source_address),
        .o_dest_address   (o_dest_address),
        .o_source_port    (o_source_port),
        .o_dest_port      (o_dest_port),
        .o_ip_length      (o_ip_length),
        .o_window_offset  (o_window_offset),
        .o_window_length  (o_window_length)
    );

endmodule

// ===== design/udp_ff_capture.sv =====
// Input register and header field capture; hands a finished frame to the judge.
module udp_ff_capture
    import udp_ff_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_frame_byte,
    input  logic             i_last_byte,
    output logic             o_snap_valid,
    input  logic             i_snap_ready,
    output t_frame           o_snap,
    output logic [POS_W-1:0] o_snap_pos
);

    logic             r_a_valid;
    logic [7:0]       r_a_byte;
    logic             r_a_last;

    t_frame           r_st;
    t_frame           n_st;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    logic             r_s_valid;
    t_frame           r_snap;
    logic [POS_W-1:0] r_snap_pos;

    logic             a_ready;
    logic             s_ready;
    logic             consume;
    logic [4:0]       base;
    logic [5:0]       hlen;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] hlen_p;

    assign s_ready = !r_s_valid || i_snap_ready;
    assign consume = r_a_valid && (!r_a_last || s_ready);
    assign a_ready = !r_a_valid || consume;

    assign base   = (r_st.outer_type == TPID_VLAN) ? VLAN_END : ETH_END;
    assign hlen   = {r_st.version_ihl[3:0], 2'b00};
    assign rel    = r_pos - POS_W'(base);
    assign hlen_p = POS_W'(hlen);

    always_comb begin
        n_st  = r_st;
        n_pos = r_pos;
        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == POS_W'(12)) n_st.outer_type[15:8] = r_a_byte;
            if (r_pos == POS_W'(13)) n_st.outer_type[7:0]  = r_a_byte;
            if (r_pos == POS_W'(16)) n_st.inner_type[15:8] = r_a_byte;
            if (r_pos == POS_W'(17)) n_st.inner_type[7:0]  = r_a_byte;
            // The outer type is complete before the IP header can start.
            if (r_pos >= POS_W'(base)) begin
                if (rel == POS_W'(0))  n_st.version_ihl         = r_a_byte;
                if (rel == POS_W'(2))  n_st.total_length[15:8]  = r_a_byte;
                if (rel == POS_W'(3))  n_st.total_length[7:0]   = r_a_byte;
                if (rel == POS_W'(9))  n_st.protocol            = r_a_byte;
                if (rel == POS_W'(12)) n_st.src_addr[31:24]     = r_a_byte;
                if (rel == POS_W'(13)) n_st.src_addr[23:16]     = r_a_byte;
                if (rel == POS_W'(14)) n_st.src_addr[15:8]      = r_a_byte;
                if (rel == POS_W'(15)) n_st.src_addr[7:0]       = r_a_byte;
                if (rel == POS_W'(16)) n_st.dst_addr[31:24]     = r_a_byte;
                if (rel == POS_W'(17)) n_st.dst_addr[23:16]     = r_a_byte;
                if (rel == POS_W'(18)) n_st.dst_addr[15:8]      = r_a_byte;
                if (rel == POS_W'(19)) n_st.dst_addr[7:0]       = r_a_byte;
                // The UDP header never overlaps the first IP header byte.
                if (rel != POS_W'(0)) begin
                    if (rel == hlen_p)              n_st.udp_sport[15:8] = r_a_byte;
                    if (rel == hlen_p + POS_W'(1))  n_st.udp_sport[7:0]  = r_a_byte;
                    if (rel == hlen_p + POS_W'(2))  n_st.udp_dport[15:8] = r_a_byte;
                    if (rel == hlen_p + POS_W'(3))  n_st.udp_dport[7:0]  = r_a_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_st      <= '0;
            r_pos     <= '0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (s_ready) begin
                r_s_valid <= consume && r_a_last;
            end
            if (consume) begin
                if (r_a_last) begin
                    r_st  <= '0;
                    r_pos <= '0;
                end else begin
                    r_st  <= n_st;
                    r_pos <= n_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_byte <= i_frame_byte;
            r_a_last <= i_last_byte;
        end
        if (consume && r_a_last) begin
            r_snap     <= n_st;
            r_snap_pos <= n_pos;
        end
    end

    assign o_in_stall   = !a_ready;
    assign o_snap_valid = r_s_valid;
    assign o_snap       = r_snap;
    assign o_snap_pos   = r_snap_pos;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position beyond frame limit");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_a_last) |=> (r_pos == '0 && r_s_valid))
        else $error("frame state not cleared after last byte");

endmodule

// ===== design/udp_ff_judge.sv =====
// Verdict logic and result register of the UDP frame filter.
module udp_ff_judge
    import udp_ff_pkg::*;
#(
    parameter int POS_W = $clog2(MAX_FRAME_BYTES_DEF + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_snap_valid,
    output logic             o_snap_ready,
    input  t_frame           i_snap,
    input  logic [POS_W-1:0] i_snap_pos,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_frame_accepted,
    output logic [2:0]       o_reject_reason,
    output logic             o_toward_server,
    output logic [31:0]      o_source_address,
    output logic [31:0]      o_dest_address,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_dest_port,
    output logic [15:0]      o_ip_length,
    output logic [6:0]       o_window_offset,
    output logic [15:0]      o_window_length
);

    logic              r_valid;
    logic              r_accepted;
    logic [2:0]        r_reason;
    logic              r_toward;
    logic [31:0]       r_src_addr;
    logic [31:0]       r_dst_addr;
    logic [15:0]       r_sport;
    logic [15:0]       r_dport;
    logic [15:0]       r_ip_len;
    logic [6:0]        r_win_off;
    logic [15:0]       r_win_len;

    logic              res_ready;
    logic [CMP_W-1:0]  n_len;
    logic [4:0]        eth;
    logic [15:0]       etype;
    logic [5:0]        hlen;
    logic [2:0]        reason;
    logic              ok;

    assign res_ready = !r_valid || !i_out_stall;
    assign n_len     = CMP_W'(i_snap_pos);
    assign hlen      = {i_snap.version_ihl[3:0], 2'b00};

    always_comb begin
        eth   = ETH_END;
        etype = i_snap.outer_type;
        // A tag is only honored when the frame reaches past it.
        if (i_snap.outer_type == TPID_VLAN && n_len >= CMP_W'(VLAN_END)) begin
            eth   = VLAN_END;
            etype = i_snap.inner_type;
        end

        if (n_len < CMP_W'(ETH_END)) begin
            reason = RSN_SHORT;
        end else if (etype != ETYPE_IPV4) begin
            reason = RSN_NOT_IPV4;
        end else if (n_len < CMP_W'(eth) + CMP_W'(IPV4_MIN)) begin
            reason = RSN_SHORT;
        end else if (i_snap.version_ihl[7:4] != IPV4_VER || hlen < IPV4_MIN) begin
            reason = RSN_BAD_HDR;
        end else if (n_len < CMP_W'(eth) + CMP_W'(hlen) + CMP_W'(UDP_HDR)) begin
            reason = RSN_SHORT;
        end else if (i_snap.protocol != PROTO_UDP) begin
            reason = RSN_NOT_UDP;
        end else if (CMP_W'(i_snap.total_length) < CMP_W'(hlen) + CMP_W'(UDP_HDR) ||
                     CMP_W'(eth) + CMP_W'(i_snap.total_length) > n_len) begin
            reason = RSN_BAD_LEN;
        end else if (i_snap.udp_sport != i_cfg.match_port &&
                     i_snap.udp_dport != i_cfg.match_port) begin
            reason = RSN_PORT;
        end else if (i_cfg.peer_filter_enable &&
                     i_cfg.peer_address != i_snap.src_addr &&
                     i_cfg.peer_address != i_snap.dst_addr) begin
            reason = RSN_PEER;
        end else begin
            reason = RSN_OK;
        end
    end

    assign ok = (reason == RSN_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_ready) begin
            r_valid <= i_snap_valid;
        end
    end

    // A rejected item carries only its reason; every other field is zero.
    always_ff @(posedge i_clk) begin
        if (res_ready) begin
            r_accepted <= ok;
            r_reason   <= reason;
            r_toward   <= ok && (i_snap.udp_dport == i_cfg.match_port);
            r_src_addr <= ok ? i_snap.src_addr : 32'd0;
            r_dst_addr <= ok ? i_snap.dst_addr : 32'd0;
            r_sport    <= ok ? i_snap.udp_sport : 16'd0;
            r_dport    <= ok ? i_snap.udp_dport : 16'd0;
            r_ip_len   <= ok ? i_snap.total_length : 16'd0;
            if (!ok) begin
                r_win_off <= 7'd0;
                r_win_len <= 16'd0;
            end else if (i_cfg.hash_payload_only) begin
                r_win_off <= 7'(eth) + 7'(hlen) + 7'(UDP_HDR);
                r_win_len <= i_snap.total_length - 16'(hlen) - 16'(UDP_HDR);
            end else begin
                r_win_off <= 7'(eth);
                r_win_len <= i_snap.total_length;
            end
        end
    end

    assign o_snap_ready     = res_ready;
    assign o_out_valid      = r_valid;
    assign o_frame_accepted = r_accepted;
    assign o_reject_reason  = r_reason;
    assign o_toward_server  = r_toward;
    assign o_source_address = r_src_addr;
    assign o_dest_address   = r_dst_addr;
    assign o_source_port    = r_sport;
    assign o_dest_port      = r_dport;
    assign o_ip_length      = r_ip_len;
    assign o_window_offset  = r_win_off;
    assign o_window_length  = r_win_len;

    a_accept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_accepted == (r_reason == RSN_OK)))
        else $error("accept flag disagrees with reject reason");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_accepted) |->
        (!r_toward && r_src_addr == 32'd0 && r_dst_addr == 32'd0 &&
         r_sport == 16'd0 && r_dport == 16'd0 && r_ip_len == 16'd0 &&
         r_win_off == 7'd0 && r_win_len == 16'd0))
        else $error("rejected item carries nonzero fields");

    a_snap_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_snap_valid && res_ready) |=> r_valid)
        else $error("frame verdict lost on the way to the result register");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for udp_frame_filter: frame stimulus, verdict prediction and comparison.
module tb_top;
    import udp_ff_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 10;
    localparam int FRAME_CAP   = MAX_FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  reason;
        logic        toward;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] iplen;
        logic [6:0]  woff;
        logic [15:0] wlen;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MATCH_PORT;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_frame_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_frame_accepted;
    logic [2:0]  o_reject_reason;
    logic        o_toward_server;
    logic [31:0] o_source_address;
    logic [31:0] o_dest_address;
    logic [15:0] o_source_port;
    logic [15:0] o_dest_port;
    logic [15:0] o_ip_length;
    logic [6:0]  o_window_offset;
    logic [15:0] o_window_length;

    t_frame_byte byte_q[$];
    t_verdict    verdict_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    logic        hold_start = 1'b0;
    int          hold_left = 0;

    // Predicted configuration and per-frame capture state.
    t_cfg        cur_cfg = '0;
    logic [16:0] frame_pos = '0;
    logic [15:0] outer_t = '0;
    logic [15:0] inner_t = '0;
    logic [7:0]  ver_ihl = '0;
    logic [7:0]  proto = '0;
    logic [15:0] tot_len = '0;
    logic [31:0] saddr = '0;
    logic [31:0] daddr = '0;
    logic [15:0] sport = '0;
    logic [15:0] dport = '0;

    udp_frame_filter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_frame_byte     (i_frame_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_accepted (o_frame_accepted),
        .o_reject_reason  (o_reject_reason),
        .o_toward_server  (o_toward_server),
        .o_source_address (o_source_address),
        .o_dest_address   (o_dest_address),
        .o_source_port    (o_source_port),
        .o_dest_port      (o_dest_port),
        .o_ip_length      (o_ip_length),
        .o_window_offset  (o_window_offset),
        .o_window_length  (o_window_length)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP) begin
            $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want,
                     cycle_count);
        end
        fail_count++;
    endtask

    function automatic void clear_capture();
        frame_pos = '0;
        outer_t   = '0;
        inner_t   = '0;
        ver_ihl   = '0;
        proto     = '0;
        tot_len   = '0;
        saddr     = '0;
        daddr     = '0;
        sport     = '0;
        dport     = '0;
    endfunction

    // Header capture for one byte at the current frame position.
    function automatic void absorb_byte(input logic [7:0] b);
        int p;
        int base;
        int rel;
        int hl;
        int ur;
        p = frame_pos;
        if (p == 12) outer_t[15:8] = b;
        if (p == 13) outer_t[7:0] = b;
        if (p == 16) inner_t[15:8] = b;
        if (p == 17) inner_t[7:0] = b;
        base = (outer_t == TPID_VLAN) ? int'(VLAN_END) : int'(ETH_END);
        if (p < base) return;
        rel = p - base;
        hl = int'(ver_ihl[3:0]) * 4;
        if (rel == 0) ver_ihl = b;
        if (rel == 2) tot_len[15:8] = b;
        if (rel == 3) tot_len[7:0] = b;
        if (rel == 9) proto = b;
        if (rel >= 12 && rel <= 15) saddr[8*(15-rel) +: 8] = b;
        if (rel >= 16 && rel <= 19) daddr[8*(19-rel) +: 8] = b;
        if (rel >= 1 && rel >= hl) begin
            ur = rel - hl;
            if (ur == 0) sport[15:8] = b;
            if (ur == 1) sport[7:0] = b;
            if (ur == 2) dport[15:8] = b;
            if (ur == 3) dport[7:0] = b;
        end
    endfunction

    function automatic logic [2:0] judge_frame();
        int n;
        int eth;
        int hl;
        logic [15:0] et;
        n = frame_pos;
        eth = int'(ETH_END);
        et = outer_t;
        hl = int'(ver_ihl[3:0]) * 4;
        if (n < int'(ETH_END)) return RSN_SHORT;
        if (outer_t == TPID_VLAN && n >= int'(VLAN_END)) begin
            et = inner_t;
            eth = int'(VLAN_END);
        end
        if (et != ETYPE_IPV4) return RSN_NOT_IPV4;
        if (n < eth + int'(IPV4_MIN)) return RSN_SHORT;
        if (ver_ihl[7:4] != IPV4_VER || hl < int'(IPV4_MIN)) return RSN_BAD_HDR;
        if (n < eth + hl + int'(UDP_HDR)) return RSN_SHORT;
        if (proto != PROTO_UDP) return RSN_NOT_UDP;
        if (int'(tot_len) < hl + int'(UDP_HDR) || eth + int'(tot_len) > n) return RSN_BAD_LEN;
        if (sport != cur_cfg.match_port && dport != cur_cfg.match_port) return RSN_PORT;
        if (cur_cfg.peer_filter_enable && cur_cfg.peer_address != saddr &&
            cur_cfg.peer_address != daddr) return RSN_PEER;
        return RSN_OK;
    endfunction

    function automatic t_verdict frame_verdict();
        t_verdict v;
        int eth;
        int hl;
        v = '0;
        v.reason = judge_frame();
        if (v.reason == RSN_OK) begin
            eth = (outer_t == TPID_VLAN) ? int'(VLAN_END) : int'(ETH_END);
            hl = int'(ver_ihl[3:0]) * 4;
            v.accepted = 1'b1;
            v.toward = (dport == cur_cfg.match_port);
            v.saddr = saddr;
            v.daddr = daddr;
            v.sport = sport;
            v.dport = dport;
            v.iplen = tot_len;
            if (cur_cfg.hash_payload_only) begin
                v.woff = 7'(eth + hl + int'(UDP_HDR));
                v.wlen = 16'(int'(tot_len) - hl - int'(UDP_HDR));
            end else begin
                v.woff = 7'(eth);
                v.wlen = tot_len;
            end
        end
        return v;
    endfunction

    // Driver: presents the next pending byte once the current one is taken.
    always @(posedge i_clk) begin : drive
        t_frame_byte nb;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_frame_byte <= '0;
            i_last_byte  <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                nb = byte_q.pop_front();
                i_in_valid   <= 1'b1;
                i_frame_byte <= nb.data;
                i_last_byte  <= nb.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Monitor: checks each taken verdict, then advances the prediction on each taken byte.
    always @(posedge i_clk) begin : watch
        t_verdict got;
        t_verdict want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_frame_accepted, o_reject_reason, o_toward_server, o_source_address,
                       o_dest_address, o_source_port, o_dest_port, o_ip_length,
                       o_window_offset, o_window_length};
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none pending", 32'(got.reason), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("frame_accepted", 32'(got.accepted), 32'(want.accepted));
                    if (got.reason !== want.reason)
                        report_mismatch("reject_reason", 32'(got.reason), 32'(want.reason));
                    if (got.toward !== want.toward)
                        report_mismatch("toward_server", 32'(got.toward), 32'(want.toward));
                    if (got.saddr !== want.saddr)
                        report_mismatch("source_address", got.saddr, want.saddr);
                    if (got.daddr !== want.daddr)
                        report_mismatch("dest_address", got.daddr, want.daddr);
                    if (got.sport !== want.sport)
                        report_mismatch("source_port", 32'(got.sport), 32'(want.sport));
                    if (got.dport !== want.dport)
                        report_mismatch("dest_port", 32'(got.dport), 32'(want.dport));
                    if (got.iplen !== want.iplen)
                        report_mismatch("ip_length", 32'(got.iplen), 32'(want.iplen));
                    if (got.woff !== want.woff)
                        report_mismatch("window_offset", 32'(got.woff), 32'(want.woff));
                    if (got.wlen !== want.wlen)
                        report_mismatch("window_length", 32'(got.wlen), 32'(want.wlen));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (int'(frame_pos) < FRAME_CAP) begin
                    absorb_byte(i_frame_byte);
                    frame_pos = frame_pos + 1'b1;
                end
                if (i_last_byte) begin
                    verdict_q.push_back(frame_verdict());
                    clear_capture();
                end
            end
        end
    end

    task automatic write_config(input t_cfg c);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MATCH_PORT;
        i_cfg_data  <= 32'(c.match_port);
        @(posedge i_clk);
        i_cfg_index <= CFG_PEER_ENABLE;
        i_cfg_data  <= 32'(c.peer_filter_enable);
        @(posedge i_clk);
        i_cfg_index <= CFG_PEER_ADDR;
        i_cfg_data  <= c.peer_address;
        @(posedge i_clk);
        i_cfg_index <= CFG_HASH_PAYLD;
        i_cfg_data  <= 32'(c.hash_payload_only);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    // Sender stops here until every predicted verdict has been seen.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic queue_noise_frame(input int flen);
        for (int k = 0; k < flen; k++) begin
            byte_q.push_back('{data: 8'($urandom), last: (k == flen - 1)});
        end
    endtask

    // Builds an Ethernet/IPv4/UDP frame of flen bytes, truncated or padded with random bytes.
    task automatic queue_udp_frame(input bit vlan_on, input logic [15:0] et,
                                   input logic [7:0] vi, input logic [7:0] pr,
                                   input logic [15:0] tl, input logic [31:0] sa,
                                   input logic [31:0] da, input logic [15:0] sp,
                                   input logic [15:0] dp, input int flen);
        logic [7:0] hd[$];
        logic [7:0] b;
        int hl;
        hl = int'(vi[3:0]) * 4;
        for (int k = 0; k < 12; k++) hd.push_back(8'($urandom));
        if (vlan_on) begin
            hd.push_back(TPID_VLAN[15:8]);
            hd.push_back(TPID_VLAN[7:0]);
            hd.push_back(8'($urandom));
            hd.push_back(8'($urandom));
        end
        hd.push_back(et[15:8]);
        hd.push_back(et[7:0]);
        hd.push_back(vi);
        hd.push_back(8'($urandom));
        hd.push_back(tl[15:8]);
        hd.push_back(tl[7:0]);
        for (int k = 0; k < 5; k++) hd.push_back(8'($urandom));
        hd.push_back(pr);
        hd.push_back(8'($urandom));
        hd.push_back(8'($urandom));
        for (int k = 3; k >= 0; k--) hd.push_back(sa[8*k +: 8]);
        for (int k = 3; k >= 0; k--) hd.push_back(da[8*k +: 8]);
        for (int k = 20; k < hl; k++) hd.push_back(8'($urandom));
        hd.push_back(sp[15:8]);
        hd.push_back(sp[7:0]);
        hd.push_back(dp[15:8]);
        hd.push_back(dp[7:0]);
        for (int k = 0; k < 4; k++) hd.push_back(8'($urandom));
        for (int k = 0; k < flen; k++) begin
            b = (k < hd.size()) ? hd[k] : 8'($urandom);
            byte_q.push_back('{data: b, last: (k == flen - 1)});
        end
    endtask

    // Mostly well-formed UDP frames with random content, some broken, some pure noise.
    task automatic queue_random_frame();
        int r;
        int hl;
        int pay;
        int eth;
        int flen;
        bit vlan_on;
        logic [15:0] et;
        logic [15:0] tl;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0] vi;
        logic [7:0] pr;
        logic [31:0] sa;
        logic [31:0] da;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            queue_noise_frame($urandom_range(1, 48));
            return;
        end
        vlan_on = ($urandom_range(0, 3) == 0);
        et = ($urandom_range(0, 19) == 0) ? 16'($urandom) : ETYPE_IPV4;
        vi = {IPV4_VER, 4'd5};
        r = $urandom_range(0, 99);
        if (r < 20) vi[3:0] = 4'($urandom_range(6, 15));
        else if (r < 25) vi[3:0] = 4'($urandom_range(0, 4));
        else if (r < 30) vi[7:4] = 4'($urandom);
        hl = int'(vi[3:0]) * 4;
        pr = ($urandom_range(0, 14) == 0) ? 8'($urandom) : PROTO_UDP;
        pay = $urandom_range(0, 20);
        tl = 16'(hl + 8 + pay);
        r = $urandom_range(0, 99);
        if (r < 6) tl = 16'($urandom);
        else if (r < 12) tl = tl - 16'($urandom_range(1, 12));
        else if (r < 16) tl = tl + 16'($urandom_range(1, 4));
        eth = vlan_on ? int'(VLAN_END) : int'(ETH_END);
        flen = eth + hl + 8 + pay;
        if ($urandom_range(0, 3) == 0) flen += $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0) flen = $urandom_range(1, flen);
        sp = 16'($urandom);
        dp = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 35) dp = cur_cfg.match_port;
        else if (r < 70) sp = cur_cfg.match_port;
        else if (r < 80) begin
            sp = cur_cfg.match_port;
            dp = cur_cfg.match_port;
        end
        sa = $urandom;
        da = $urandom;
        r = $urandom_range(0, 99);
        if (r < 40) sa = cur_cfg.peer_address;
        else if (r < 70) da = cur_cfg.peer_address;
        queue_udp_frame(vlan_on, et, vi, pr, tl, sa, da, sp, dp, flen);
    endtask

    task automatic set_idling(input int snd, input int rcv);
        @(negedge i_clk);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
    endtask

    initial begin : stimulus
        t_cfg c;
        int start_size;
        logic [15:0] mp;
        logic [31:0] pa;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(15, 50);
        mp = 16'h1234;
        pa = 32'hC0A8_0001;
        c = '{match_port: mp, peer_filter_enable: 1'b1, peer_address: pa,
              hash_payload_only: 1'b1};
        write_config(c);
        @(negedge i_clk);
        queue_noise_frame(1);
        queue_noise_frame(13);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, pa, 0, mp, mp, 14);
        queue_udp_frame(0, 16'h86DD, 8'h45, PROTO_UDP, 16'd28, pa, 0, mp, mp, 60);
        // Tag present but the frame ends before the inner type.
        queue_udp_frame(1, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, pa, 0, mp, mp, 16);
        queue_udp_frame(1, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd36, pa, 32'h0A00_0002,
                        16'h0035, mp, 54);
        queue_udp_frame(0, ETYPE_IPV4, 8'h65, PROTO_UDP, 16'd28, pa, 0, mp, mp, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h44, PROTO_UDP, 16'd28, pa, 0, mp, mp, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h4F, PROTO_UDP, 16'd72, 0, pa, mp, 0, 86);
        queue_udp_frame(1, ETYPE_IPV4, 8'h4F, PROTO_UDP, 16'd68, 32'hFFFF_FFFF, pa,
                        mp, 16'hFFFF, 86);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, 8'd6, 16'd28, pa, 0, mp, mp, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd27, pa, 0, mp, mp, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd40, pa, 0, mp, mp, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, pa, 0, 16'hFFFF, 0, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, 32'hFFFF_FFFF, 0,
                        mp, mp, 42);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, pa, 0, mp, mp, 38);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, pa, 0, mp, mp, 33);
        queue_udp_frame(0, 16'h0000, 8'h00, 8'h00, 16'h0000, 0, 0, 0, 0, 64);
        queue_udp_frame(0, ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd28, 0, pa, mp, mp, 60);
        wait_drained();

        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: c = '{16'h0000, 1'b0, 32'hFFFF_FFFF, 1'b0};
                2: c = '{16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1};
                3: c = '{16'($urandom), 1'b1, 32'h0000_0000, 1'b0};
                4: c = '{16'($urandom), 1'b0, 32'($urandom), 1'b1};
                default: c = '{16'($urandom), 1'b1, 32'($urandom), 1'b1};
            endcase
            if (ph == 1) set_idling(15, 50);
            else if (ph <= 3) set_idling(50, 15);
            else set_idling(0, 0);
            write_config(c);
            @(negedge i_clk);
            if (ph == 4) begin
                // Many short frames behind a long output hold-off back the block up.
                for (int k = 0; k < 20; k++) queue_noise_frame($urandom_range(1, 13));
            end
            start_size = byte_q.size();
            while (byte_q.size() - start_size < 48) begin
                queue_random_frame();
            end
            if (ph == 4) begin
                @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            wait_drained();
        end

        if (verdict_q.size() != 0) report_mismatch("verdicts never seen", verdict_q.size(), 0);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
